// ===== design/wkrc_pkg.sv =====
// ----------------------------------------------------------------------------
// wkrc_pkg: shared types and constants
// Payload words, register map, command codes and the controller/datapath
// interface of the wrapped-kernel RGBA convolution block.
// ----------------------------------------------------------------------------
package wkrc_pkg;

   // input command codes
   typedef enum logic [1:0] {
      CMD_WRITE_PIXEL = 2'd0,
      CMD_WRITE_COEF  = 2'd1,
      CMD_COMPUTE     = 2'd2
   } cmd_type;

   // register map, word index into the csr space
   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH   = 3'd0,
      REG_IMAGE_HEIGHT  = 3'd1,
      REG_KERNEL_WIDTH  = 3'd2,
      REG_KERNEL_HEIGHT = 3'd3,
      REG_SCALE_FACTOR  = 3'd4,
      REG_BIAS          = 3'd5
   } reg_index_type;

   // input word
   typedef struct packed {
      logic [1:0]         cmd;
      logic [7:0]         pos_x;
      logic [7:0]         pos_y;
      logic [31:0]        pixel_word;
      logic [6:0]         coef_index;
      logic signed [15:0] coef_value;
   } req_word_type;

   // result word
   typedef struct packed {
      logic [31:0] filtered_pixel;
      logic [7:0]  out_x;
      logic [7:0]  out_y;
   } rsp_word_type;

   // configuration registers
   typedef struct packed {
      logic [8:0]         image_width;
      logic [8:0]         image_height;
      logic [3:0]         kernel_width;
      logic [3:0]         kernel_height;
      logic [15:0]        scale_factor;
      logic signed [17:0] bias;
   } cfg_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_ADJ,
      ST_RUN,
      ST_DRAIN,
      ST_SCALE,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic load;
      logic mod_step;
      logic adj_init;
      logic adj_step;
      logic win_init;
      logic tap_issue;
      logic scale;
      logic finish;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic mod_done;
      logic adj_done;
      logic no_taps;
      logic last_tap;
      logic pipe_busy;
      logic out_free;
   } dp_status_type;

   // fixed point positions
   localparam int FRAC_BITS  = 20;
   localparam int BIAS_SHIFT = 12;
   localparam logic [7:0] CHAN_MAX = 8'hff;

endpackage

// ===== design/wrapped_kernel_rgba_convolution.sv =====
// ----------------------------------------------------------------------------
// wrapped_kernel_rgba_convolution: RGBA 2-D convolution with wraparound
// Frame store, kernel store, csr registers and one compute sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready) carries one word per command: write a pixel,
//   write a kernel coefficient, or compute the filtered pixel at (x, y).
//   Writes give no result. A compute gives one rsp word.
//   csr port (apb style, pready always high) sets image and kernel size,
//   scale factor and bias; write it only while the block is idle.
//   A compute first reduces x mod width and y mod height, both axes
//   reduced in parallel, then starts the wrapped window and reads each
//   kernel tap (kernel_width * kernel_height, nine for 3x3) in turn through
//   the single frame-store read port, then drains, scales, adds the bias
//   and clamps. One compute is in flight.
//   The rsp register holds a finished word while the next req is taken;
//   a stalled receiver holds the next compute in its final cycle.
//   Reset clears the sequencer, result valid and csr registers to their
//   defaults; the frame and kernel stores are undefined until written.
// ----------------------------------------------------------------------------
module wrapped_kernel_rgba_convolution
   import wkrc_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int MAX_KERNEL = 9
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   cfg_type       cfg_ff;
   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic [2:0]    csr_index;
   logic          csr_write;

   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width   <= 9'd256;
         cfg_ff.image_height  <= 9'd256;
         cfg_ff.kernel_width  <= 4'd3;
         cfg_ff.kernel_height <= 4'd3;
         cfg_ff.scale_factor  <= 16'd4096;
         cfg_ff.bias          <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:   cfg_ff.image_width   <= csr_pwdata[8:0];
            REG_IMAGE_HEIGHT:  cfg_ff.image_height  <= csr_pwdata[8:0];
            REG_KERNEL_WIDTH:  cfg_ff.kernel_width  <= csr_pwdata[3:0];
            REG_KERNEL_HEIGHT: cfg_ff.kernel_height <= csr_pwdata[3:0];
            REG_SCALE_FACTOR:  cfg_ff.scale_factor  <= csr_pwdata[15:0];
            REG_BIAS:          cfg_ff.bias          <= csr_pwdata[17:0];
            default: begin
            end
         endcase
      end
   end

   // csr read back
   always_comb begin
      unique case (csr_index)
         REG_IMAGE_WIDTH:   csr_prdata = 32'(cfg_ff.image_width);
         REG_IMAGE_HEIGHT:  csr_prdata = 32'(cfg_ff.image_height);
         REG_KERNEL_WIDTH:  csr_prdata = 32'(cfg_ff.kernel_width);
         REG_KERNEL_HEIGHT: csr_prdata = 32'(cfg_ff.kernel_height);
         REG_SCALE_FACTOR:  csr_prdata = 32'(cfg_ff.scale_factor);
         REG_BIAS:          csr_prdata = 32'(cfg_ff.bias);
         default:           csr_prdata = '0;
      endcase
   end

   // sequencer
   wkrc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .is_compute (req_word.cmd == CMD_COMPUTE),
      .status     (status),
      .req_ready  (req_ready),
      .cmd        (cmd)
   );

   // datapath
   wkrc_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_KERNEL (MAX_KERNEL)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_word  (req_word),
      .cfg       (cfg_ff),
      .rsp_ready (rsp_ready),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

// ===== design/wkrc_ram.sv =====
// ----------------------------------------------------------------------------
// wkrc_ram: generic simple dual-port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wkrc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/wkrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// wkrc_ctrl: sequencer
// Walks one compute through coordinate reduction, window start, tap issue,
// pipeline drain, scaling and result hand-off.
// ----------------------------------------------------------------------------
module wkrc_ctrl
   import wkrc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          is_compute,
   input  dp_status_type status,
   output logic          req_ready,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (is_compute) begin
                  cmd.load = 1'b1;
                  state_in = ST_MOD;
               end
            end
         end
         ST_MOD: begin
            if (status.mod_done) begin
               cmd.adj_init = 1'b1;
               state_in     = ST_ADJ;
            end else begin
               cmd.mod_step = 1'b1;
            end
         end
         ST_ADJ: begin
            if (status.adj_done) begin
               cmd.win_init = 1'b1;
               state_in     = status.no_taps ? ST_SCALE : ST_RUN;
            end else begin
               cmd.adj_step = 1'b1;
            end
         end
         ST_RUN: begin
            cmd.tap_issue = 1'b1;
            if (status.last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
      endcase
   end

endmodule

// ===== design/wkrc_dp.sv =====
// ----------------------------------------------------------------------------
// wkrc_dp: convolution datapath
// Frame and coefficient stores, wrapped window walk, per-channel
// multiply-accumulate, scale, bias, clamp and the result register.
// ----------------------------------------------------------------------------
module wkrc_dp
   import wkrc_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int MAX_KERNEL = 9
) (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   input  req_word_type  req_word,
   input  cfg_type       cfg,
   input  logic          rsp_ready,
   output dp_status_type status,
   output logic          rsp_valid,
   output rsp_word_type  rsp_word
);

   localparam int CW0      = $clog2(MAX_WIDTH + 1);
   localparam int CW1      = $clog2(MAX_HEIGHT + 1);
   localparam int CW2      = (CW0 > CW1) ? CW0 : CW1;
   localparam int CW       = (CW2 > 10) ? CW2 : 10;
   localparam int KW       = $clog2(MAX_KERNEL + 1);
   localparam int N_COEF   = MAX_KERNEL * MAX_KERNEL;
   localparam int CI_W     = $clog2(N_COEF);
   localparam int FA_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int FA_W     = $clog2(FA_DEPTH);
   localparam int PROD_W   = 25;
   localparam int ACC_W    = PROD_W + $clog2(N_COEF);
   localparam int SCL_W    = ACC_W + 17;
   localparam int SUM_W    = SCL_W + 1;

   // effective sizes
   logic [CW-1:0] w_eff, h_eff;
   logic [KW-1:0] kw_eff, kh_eff;

   always_comb begin
      if (cfg.image_width == '0) begin
         w_eff = CW'(1);
      end else if (CW'(cfg.image_width) > CW'(MAX_WIDTH)) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = CW'(cfg.image_width);
      end
      if (cfg.image_height == '0) begin
         h_eff = CW'(1);
      end else if (CW'(cfg.image_height) > CW'(MAX_HEIGHT)) begin
         h_eff = CW'(MAX_HEIGHT);
      end else begin
         h_eff = CW'(cfg.image_height);
      end
      if (cfg.kernel_width > 4'(MAX_KERNEL)) begin
         kw_eff = KW'(MAX_KERNEL);
      end else begin
         kw_eff = KW'(cfg.kernel_width);
      end
      if (cfg.kernel_height > 4'(MAX_KERNEL)) begin
         kh_eff = KW'(MAX_KERNEL);
      end else begin
         kh_eff = KW'(cfg.kernel_height);
      end
   end

   // window walk registers
   logic [CW-1:0]   xr_ff, yr_ff, ix_ff, iy_ff;
   logic [CW:0]     xs_ff, ys_ff;
   logic [KW-1:0]   fx_ff, fy_ff;
   logic [CI_W-1:0] ci_ff;
   logic [7:0]      posx_ff, posy_ff;
   logic [CW-1:0]   ix_next, iy_next;
   logic            row_end;

   assign row_end = (fx_ff == kw_eff - KW'(1));
   assign ix_next = (ix_ff + CW'(1) == w_eff) ? '0 : ix_ff + CW'(1);
   assign iy_next = (iy_ff + CW'(1) == h_eff) ? '0 : iy_ff + CW'(1);

   // coordinate reduction, window start and tap stepping
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         xr_ff   <= CW'(req_word.pos_x);
         yr_ff   <= CW'(req_word.pos_y);
         posx_ff <= req_word.pos_x;
         posy_ff <= req_word.pos_y;
      end
      if (cmd.mod_step) begin
         if (xr_ff >= w_eff) begin
            xr_ff <= xr_ff - w_eff;
         end
         if (yr_ff >= h_eff) begin
            yr_ff <= yr_ff - h_eff;
         end
      end
      if (cmd.adj_init) begin
         xs_ff <= {1'b0, xr_ff} - {{(CW + 1 - KW){1'b0}}, kw_eff >> 1};
         ys_ff <= {1'b0, yr_ff} - {{(CW + 1 - KW){1'b0}}, kh_eff >> 1};
      end
      if (cmd.adj_step) begin
         if (xs_ff[CW]) begin
            xs_ff <= xs_ff + {1'b0, w_eff};
         end
         if (ys_ff[CW]) begin
            ys_ff <= ys_ff + {1'b0, h_eff};
         end
      end
      if (cmd.win_init) begin
         ix_ff <= xs_ff[CW-1:0];
         iy_ff <= ys_ff[CW-1:0];
         fx_ff <= '0;
         fy_ff <= '0;
         ci_ff <= '0;
      end
      if (cmd.tap_issue) begin
         ci_ff <= ci_ff + CI_W'(1);
         if (row_end) begin
            fx_ff <= '0;
            fy_ff <= fy_ff + KW'(1);
            ix_ff <= xs_ff[CW-1:0];
            iy_ff <= iy_next;
         end else begin
            fx_ff <= fx_ff + KW'(1);
            ix_ff <= ix_next;
         end
      end
   end

   // frame store
   logic              frame_we;
   logic [FA_W-1:0]   frame_waddr, frame_raddr;
   logic [31:0]       frame_rdata;

   assign frame_we = cmd.accept && (req_word.cmd == CMD_WRITE_PIXEL)
                     && (32'(req_word.pos_x) < 32'(MAX_WIDTH))
                     && (32'(req_word.pos_y) < 32'(MAX_HEIGHT));
   assign frame_waddr = FA_W'(32'(req_word.pos_y) * 32'(MAX_WIDTH)
                        + 32'(req_word.pos_x));
   assign frame_raddr = FA_W'(32'(iy_ff) * 32'(MAX_WIDTH) + 32'(ix_ff));

   wkrc_ram #(.WIDTH(32), .DEPTH(FA_DEPTH)) u_frame (
      .clock (clock),
      .we    (frame_we),
      .waddr (frame_waddr),
      .wdata (req_word.pixel_word),
      .raddr (frame_raddr),
      .rdata (frame_rdata)
   );

   // coefficient store
   logic        coef_we;
   logic [15:0] coef_rdata;

   assign coef_we = cmd.accept && (req_word.cmd == CMD_WRITE_COEF)
                    && (32'(req_word.coef_index) < 32'(N_COEF));

   wkrc_ram #(.WIDTH(16), .DEPTH(N_COEF)) u_coef (
      .clock (clock),
      .we    (coef_we),
      .waddr (CI_W'(req_word.coef_index)),
      .wdata (req_word.coef_value),
      .raddr (ci_ff),
      .rdata (coef_rdata)
   );

   // multiply-accumulate pipeline
   logic                      v1_ff, v2_ff;
   logic signed [PROD_W-1:0]  prod_ff [4];
   logic signed [ACC_W-1:0]   acc_ff [4];
   logic signed [SCL_W-1:0]   scl_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.tap_issue;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 4; c++) begin
         prod_ff[c] <= $signed(coef_rdata) * $signed({1'b0, frame_rdata[8*c +: 8]});
         if (cmd.load) begin
            acc_ff[c] <= '0;
         end else if (v2_ff) begin
            acc_ff[c] <= acc_ff[c] + ACC_W'(prod_ff[c]);
         end
         if (cmd.scale) begin
            scl_ff[c] <= acc_ff[c] * $signed({1'b0, cfg.scale_factor});
         end
      end
   end

   // bias, clamp and pack
   logic signed [SUM_W-1:0] bias_ext;
   logic signed [SUM_W-1:0] sum_val [4];
   logic [31:0]             packed_pix;

   assign bias_ext = SUM_W'(cfg.bias);

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         sum_val[c] = scl_ff[c] + (bias_ext <<< BIAS_SHIFT);
         if (sum_val[c][SUM_W-1]) begin
            packed_pix[8*c +: 8] = '0;
         end else if (|sum_val[c][SUM_W-2:FRAC_BITS+8]) begin
            packed_pix[8*c +: 8] = CHAN_MAX;
         end else begin
            packed_pix[8*c +: 8] = sum_val[c][FRAC_BITS +: 8];
         end
      end
   end

   // result register
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_word_ff.filtered_pixel <= packed_pix;
         rsp_word_ff.out_x          <= posx_ff;
         rsp_word_ff.out_y          <= posy_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // status to the sequencer
   assign status.mod_done  = (xr_ff < w_eff) && (yr_ff < h_eff);
   assign status.adj_done  = !xs_ff[CW] && !ys_ff[CW];
   assign status.no_taps   = (kw_eff == '0) || (kh_eff == '0);
   assign status.last_tap  = row_end && (fy_ff == kh_eff - KW'(1));
   assign status.pipe_busy = v1_ff || v2_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // checks
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("result not presented after finish");

   a_pipe_order: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> $past(v1_ff))
      else $error("product stage valid without read stage");

   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      cmd.tap_issue |-> (ix_ff < w_eff) && (iy_ff < h_eff))
      else $error("window coordinate outside image");

   a_scale_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.scale |-> !v1_ff && !v2_ff)
      else $error("scaling before accumulate drained");

endmodule
